>>> design/assert_macros.svh
// Assertion macros used by the checker module of the project.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal that must hold whenever the enabling condition is true.
`define ASSERT_WHEN(label, cond, expr, msg) \
    `ASSERT_CLK(label, (cond) |-> (expr), msg)

`endif

>>> design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int U8D_QUEUE_DEPTH = 4;

    localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;

    // One input transaction: a raw byte and the end-of-text mark.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       text_end;
    } byte_item_t;

    // One result transaction: a decoded character or an invalid prefix.
    typedef struct packed {
        logic [20:0] code_point;
        logic        well_formed;
        logic [2:0]  seq_length;
        logic        run_last;
        logic        text_done;
    } char_item_t;

    // What the front hands to the back for one byte: one or two results.
    typedef struct packed {
        logic       two;
        char_item_t first;
        char_item_t second;
    } cmd_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

endpackage

>>> design/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder with strict well-formedness checking.
// ----------------------------------------------------------------------------
// Usage:
// Bytes arrive on the byte channel (byte_valid, byte_stall, byte_item), one
// transaction per byte, with text_end set on the last byte of a text.
// Decoded characters leave on the char channel (char_valid, char_stall,
// char_item): code point, well-formed flag, length, and the run_last and
// text_done marks. Malformed or truncated input gives U+FFFD with the length
// of the maximal well-formed prefix.
// A byte is taken in every cycle while the command queue has room; the
// queue is QUEUE_DEPTH entries deep. A byte continuing a sequence gives no
// transaction; a byte that breaks a sequence may give two, which the output
// stage sends one after the other; the back sustains one result a cycle
// while the receiver does not stall. Results pass through the queue, then the
// output register; while the receiver stalls, they wait in the output register
// and the queue. Once the queue is full, byte_stall rises.
// Reset clears the pending sequence, the queue and the output register.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = U8D_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    output logic       char_valid,
    input  logic       char_stall,
    output char_item_t char_item
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;

    u8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

endmodule

>>> design/u8d_queue.sv
// ----------------------------------------------------------------------------
// u8d_queue
// Small FIFO of decode commands between the front and the back.
// ----------------------------------------------------------------------------
module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = U8D_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full     = (count_reg == CNT_W'(DEPTH));
    assign status.nonempty = (count_reg != '0);
    assign do_push         = push && !status.full;
    assign do_pop          = pop && status.nonempty;
    assign head            = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front
// Accepts bytes, tracks the pending sequence and forms the results of each byte.
// ----------------------------------------------------------------------------
module u8d_front
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    input  q_status_t  q_status,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam logic [2:0] LC_NONE  = 3'd0;
    localparam logic [2:0] LC_TWO   = 3'd1;
    localparam logic [2:0] LC_E0    = 3'd2;
    localparam logic [2:0] LC_E1    = 3'd3;
    localparam logic [2:0] LC_ED    = 3'd4;
    localparam logic [2:0] LC_F0    = 3'd5;
    localparam logic [2:0] LC_F1    = 3'd6;
    localparam logic [2:0] LC_F4    = 3'd7;

    typedef struct packed {
        logic        emit;
        char_item_t  res;
        logic [2:0]  cls;
        logic [14:0] pay;
        logic [1:0]  need;
    } lead_t;

    function automatic char_item_t bad_item(input logic [2:0] len);
        char_item_t r;
        r            = '0;
        r.code_point = REPLACEMENT_CHAR;
        r.seq_length = len;
        return r;
    endfunction

    // Decodes a byte as the start of a new sequence.
    function automatic lead_t take_lead(input logic [7:0] b, input logic fin);
        lead_t l;
        l      = '0;
        l.cls  = LC_NONE;
        priority if (b <= 8'h7F)
        begin
            l.emit           = 1'b1;
            l.res.code_point = {13'd0, b};
            l.res.well_formed = 1'b1;
            l.res.seq_length = 3'd1;
        end
        else if (b >= 8'hC2 && b <= 8'hDF)
        begin
            l.cls = LC_TWO; l.pay = {10'd0, b[4:0]}; l.need = 2'd1;
        end
        else if (b == 8'hE0)
        begin
            l.cls = LC_E0; l.pay = {11'd0, b[3:0]}; l.need = 2'd2;
        end
        else if (b == 8'hED)
        begin
            l.cls = LC_ED; l.pay = {11'd0, b[3:0]}; l.need = 2'd2;
        end
        else if (b >= 8'hE1 && b <= 8'hEF)
        begin
            l.cls = LC_E1; l.pay = {11'd0, b[3:0]}; l.need = 2'd2;
        end
        else if (b == 8'hF0)
        begin
            l.cls = LC_F0; l.pay = {12'd0, b[2:0]}; l.need = 2'd3;
        end
        else if (b >= 8'hF1 && b <= 8'hF3)
        begin
            l.cls = LC_F1; l.pay = {12'd0, b[2:0]}; l.need = 2'd3;
        end
        else if (b == 8'hF4)
        begin
            l.cls = LC_F4; l.pay = {12'd0, b[2:0]}; l.need = 2'd3;
        end
        else
        begin
            l.emit = 1'b1;
            l.res  = bad_item(3'd1);
        end
        // A valid lead byte that ends the text is a truncated sequence.
        if (!l.emit && fin)
        begin
            l.emit = 1'b1;
            l.res  = bad_item(3'd1);
        end
        return l;
    endfunction

    logic [14:0] partial_reg;
    logic [14:0] partial_next;
    logic [2:0]  cls_reg;
    logic [2:0]  cls_next;
    logic [1:0]  held_reg;
    logic [1:0]  held_next;
    logic [1:0]  need_reg;
    logic [1:0]  need_next;

    logic        accept;
    logic        emit;
    logic        load_lead;
    logic        cont_ok;
    logic [7:0]  lo_bound;
    logic [7:0]  hi_bound;
    logic [20:0] cp_ext;
    logic [2:0]  held_inc;
    logic [1:0]  need_dec;
    lead_t       lead;
    cmd_t        cmd;

    assign byte_stall = q_status.full;
    assign accept     = byte_valid && !q_status.full;
    assign push       = accept && emit;
    assign push_cmd   = cmd;

    // The second byte of some lead bytes has a narrower range.
    always_comb
    begin
        lo_bound = 8'h80;
        hi_bound = 8'hBF;
        if (held_reg == 2'd1)
        begin
            unique case (cls_reg)
                LC_E0:   lo_bound = 8'hA0;
                LC_ED:   hi_bound = 8'h9F;
                LC_F0:   lo_bound = 8'h90;
                LC_F4:   hi_bound = 8'h8F;
                default: ;
            endcase
        end
        cont_ok = (byte_item.byte_in >= lo_bound) && (byte_item.byte_in <= hi_bound);
    end

    assign cp_ext   = {partial_reg, byte_item.byte_in[5:0]};
    assign held_inc = {1'b0, held_reg} + 3'd1;
    assign need_dec = need_reg - 2'd1;

    always_comb
    begin
        lead         = take_lead(byte_item.byte_in, byte_item.text_end);
        cmd          = '0;
        emit         = 1'b0;
        load_lead    = 1'b0;
        partial_next = partial_reg;
        cls_next     = cls_reg;
        held_next    = held_reg;
        need_next    = need_reg;
        priority if (need_reg == 2'd0)
        begin
            emit      = lead.emit;
            cmd.first = lead.res;
            load_lead = !lead.emit;
        end
        else if (cont_ok)
        begin
            if (need_dec == 2'd0)
            begin
                emit                  = 1'b1;
                cmd.first.code_point  = cp_ext;
                cmd.first.well_formed = 1'b1;
                cmd.first.seq_length  = held_inc;
            end
            else if (byte_item.text_end)
            begin
                emit      = 1'b1;
                cmd.first = bad_item(held_inc);
            end
            else
            begin
                partial_next = cp_ext[14:0];
                held_next    = held_inc[1:0];
                need_next    = need_dec;
            end
        end
        else
        begin
            // The breaking byte closes the prefix and is then taken as a lead byte.
            emit       = 1'b1;
            cmd.first  = bad_item({1'b0, held_reg});
            cmd.two    = lead.emit;
            cmd.second = lead.res;
            load_lead  = !lead.emit;
        end

        if (load_lead)
        begin
            partial_next = lead.pay;
            cls_next     = lead.cls;
            held_next    = 2'd1;
            need_next    = lead.need;
        end
        else if (emit || byte_item.text_end)
        begin
            partial_next = '0;
            cls_next     = LC_NONE;
            held_next    = '0;
            need_next    = '0;
        end

        if (cmd.two)
        begin
            cmd.second.run_last  = 1'b1;
            cmd.second.text_done = byte_item.text_end;
        end
        else
        begin
            cmd.first.run_last  = 1'b1;
            cmd.first.text_done = byte_item.text_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            cls_reg     <= LC_NONE;
            held_reg    <= '0;
            need_reg    <= '0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            cls_reg     <= cls_next;
            held_reg    <= held_next;
            need_reg    <= need_next;
        end
    end

endmodule

>>> design/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back
// Takes queue commands and shows their results one per cycle while not stalled.
// ----------------------------------------------------------------------------
module u8d_back
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       char_valid,
    input  logic       char_stall,
    output char_item_t char_item
);

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } phase_t;

    phase_t     phase_reg;
    logic       valid_reg;
    char_item_t item_reg;
    logic       load;

    // The output register may refill when it is empty or being taken.
    assign load       = !valid_reg || !char_stall;
    assign pop        = load && q_status.nonempty && (phase_reg == PH_SECOND || !head.two);
    assign char_valid = valid_reg;
    assign char_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            valid_reg <= 1'b0;
            item_reg  <= '0;
        end
        else if (load)
        begin
            valid_reg <= q_status.nonempty;
            if (q_status.nonempty)
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        item_reg  <= head.first;
                        phase_reg <= head.two ? PH_SECOND : PH_FIRST;
                    end
                    PH_SECOND:
                    begin
                        item_reg  <= head.second;
                        phase_reg <= PH_FIRST;
                    end
                endcase
            end
        end
    end

endmodule

>>> design/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the results of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8d_checker
    import u8d_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       char_valid,
    input logic       char_stall,
    input char_item_t char_item
);

    // A stalled result must stay on the port unchanged.
    `ASSERT_CLK(a_stall_hold, char_valid && char_stall |=> char_valid && $stable(char_item), "stalled result changed")

    // Every invalid result carries the replacement character.
    `ASSERT_WHEN(a_bad_is_fffd, char_valid && !char_item.well_formed, char_item.code_point == REPLACEMENT_CHAR, "invalid result without U+FFFD")

    // The result that closes a text is also the last one of its byte.
    `ASSERT_WHEN(a_done_last, char_valid && char_item.text_done, char_item.run_last, "text_done without run_last")

    // A well-formed single byte is plain ASCII.
    `ASSERT_WHEN(a_ascii_len, char_valid && char_item.well_formed && char_item.seq_length == 3'd1, char_item.code_point <= 21'h7F, "one-byte character above U+007F")

endmodule

bind utf8_stream_decoder u8d_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
);

>>> sim/utf8_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Self-checking testbench for the streaming UTF-8 decoder.
// Bytes are sent one at a time. A behavioural decoder inside the bench tracks
// the pending sequence and queues the characters that each byte should give.
// Every character that leaves the block is compared field by field with the
// oldest queued character. Directed cases come first. They are followed by
// random text, mostly well-formed with some broken and noisy bytes, under
// three different patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_test
    import u8d_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_BYTES  = 550;

    // Kind of lead byte; it fixes the allowed range of the second byte.
    typedef enum logic [2:0] {
        LEAD_NONE,
        LEAD_TWO,
        LEAD_E0,
        LEAD_THREE,
        LEAD_ED,
        LEAD_F0,
        LEAD_FOUR,
        LEAD_F4
    } lead_kind_e;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    byte_item_t byte_item = '0;
    logic       char_valid;
    logic       char_stall = 1'b0;
    char_item_t char_item;

    // Decoder state as the bench sees it.
    logic [14:0] acc_bits;
    lead_kind_e  lead_kind;
    logic [1:0]  bytes_taken;
    logic [1:0]  bytes_missing;

    char_item_t step_chars[$];
    char_item_t pending_chars[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int bytes_sent = 0;
    int chars_checked = 0;
    int malformed_count = 0;
    int texts_closed = 0;
    int double_bytes = 0;
    int cycle_count = 0;

    utf8_stream_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        char_stall <= ($urandom_range(99) < stall_pct);

    // ------------------------------------------------------------------
    // Behavioural decoder
    // ------------------------------------------------------------------
    function automatic char_item_t make_char(logic [20:0] cp, logic ok, logic [2:0] len);
        char_item_t c;
        c = '0;
        c.code_point = cp;
        c.well_formed = ok;
        c.seq_length = len;
        return c;
    endfunction

    task clear_sequence;
        acc_bits = '0;
        lead_kind = LEAD_NONE;
        bytes_taken = '0;
        bytes_missing = '0;
    endtask

    task take_lead_byte(input logic [7:0] b, input logic last);
        lead_kind_e  kind;
        logic [14:0] payload;
        logic [1:0]  need;
        kind = LEAD_NONE;
        payload = '0;
        need = '0;
        if (b <= 8'h7F)
            step_chars.push_back(make_char({13'd0, b}, 1'b1, 3'd1));
        else
        begin
            if (b >= 8'hC2 && b <= 8'hDF)
            begin
                kind = LEAD_TWO;
                payload = {10'd0, b[4:0]};
                need = 2'd1;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                kind = (b == 8'hE0) ? LEAD_E0 : (b == 8'hED) ? LEAD_ED : LEAD_THREE;
                payload = {11'd0, b[3:0]};
                need = 2'd2;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                kind = (b == 8'hF0) ? LEAD_F0 : (b == 8'hF4) ? LEAD_F4 : LEAD_FOUR;
                payload = {12'd0, b[2:0]};
                need = 2'd3;
            end
            // A bad lead, or a good lead that is the last byte of the text,
            // is a malformed character of one byte.
            if (kind == LEAD_NONE || last)
                step_chars.push_back(make_char(REPLACEMENT_CHAR, 1'b0, 3'd1));
            else
            begin
                acc_bits = payload;
                lead_kind = kind;
                bytes_taken = 2'd1;
                bytes_missing = need;
            end
        end
    endtask

    function automatic logic continuation_fits(logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (bytes_taken == 2'd1)
        begin
            case (lead_kind)
                LEAD_E0: lo = 8'hA0;
                LEAD_ED: hi = 8'h9F;
                LEAD_F0: lo = 8'h90;
                LEAD_F4: hi = 8'h8F;
                default: ;
            endcase
        end
        return (b >= lo) && (b <= hi);
    endfunction

    task predict_byte(input logic [7:0] b, input logic last);
        logic [20:0] cp;
        logic [2:0]  held;
        logic [1:0]  need;
        char_item_t  c;
        step_chars.delete();
        if (bytes_missing == 2'd0)
        begin
            clear_sequence();
            take_lead_byte(b, last);
        end
        else if (continuation_fits(b))
        begin
            cp = {acc_bits, b[5:0]};
            held = {1'b0, bytes_taken} + 3'd1;
            need = bytes_missing - 2'd1;
            if (need == 2'd0)
            begin
                step_chars.push_back(make_char(cp, 1'b1, held));
                clear_sequence();
            end
            else if (last)
            begin
                step_chars.push_back(make_char(REPLACEMENT_CHAR, 1'b0, held));
                clear_sequence();
            end
            else
            begin
                acc_bits = cp[14:0];
                bytes_taken = held[1:0];
                bytes_missing = need;
            end
        end
        else
        begin
            // The breaking byte closes the prefix and then starts afresh.
            step_chars.push_back(make_char(REPLACEMENT_CHAR, 1'b0, {1'b0, bytes_taken}));
            clear_sequence();
            take_lead_byte(b, last);
        end
        if (last)
            clear_sequence();
        if (step_chars.size() > 0)
        begin
            c = step_chars.pop_back();
            c.run_last = 1'b1;
            c.text_done = last;
            step_chars.push_back(c);
        end
        if (step_chars.size() == 2)
            double_bytes++;
        foreach (step_chars[i])
        begin
            if (!step_chars[i].well_formed)
                malformed_count++;
            if (step_chars[i].text_done)
                texts_closed++;
            pending_chars.push_back(step_chars[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task check_field(input string field, input logic [20:0] want, input logic [20:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        char_item_t want;
        if (rst_n && char_valid && !char_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, got cp 0x%0h ok %0b len %0d",
                         $time, char_item.code_point, char_item.well_formed,
                         char_item.seq_length);
                errors++;
            end
            else
            begin
                want = pending_chars.pop_front();
                check_field("code_point", want.code_point, char_item.code_point);
                check_field("well_formed", {20'd0, want.well_formed},
                            {20'd0, char_item.well_formed});
                check_field("seq_length", {18'd0, want.seq_length},
                            {18'd0, char_item.seq_length});
                check_field("run_last", {20'd0, want.run_last}, {20'd0, char_item.run_last});
                check_field("text_done", {20'd0, want.text_done},
                            {20'd0, char_item.text_done});
                chars_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= '{byte_in: b, text_end: last};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        predict_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Holds the byte channel idle until every queued character has come out.
    task wait_for_results;
        byte_valid <= 1'b0;
        @(negedge clk);
        while (pending_chars.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic random_end();
        return ($urandom_range(99) < 4);
    endfunction

    function automatic logic [20:0] pick_scalar(int len);
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        case (len)
            1: begin lo = 21'h0;     hi = 21'h7F;     end
            2: begin lo = 21'h80;    hi = 21'h7FF;    end
            3: begin lo = 21'h800;   hi = 21'hFFFF;   end
            default: begin lo = 21'h10000; hi = 21'h10FFFF; end
        endcase
        case ($urandom_range(9))
            0: cp = lo;
            1: cp = hi;
            default: cp = lo + 21'($urandom_range(hi - lo));
        endcase
        // Steer clear of surrogates; the flipped value stays in range.
        if (len == 3 && cp >= 21'hD800 && cp <= 21'hDFFF)
            cp = cp ^ 21'h2000;
        return cp;
    endfunction

    // Encodes a scalar of the given length and sends its first few bytes.
    task send_scalar(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] enc [4];
        case (len)
            1: enc[0] = cp[7:0];
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            send_byte(enc[i], random_end());
    endtask

    task test_single_bytes;
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC1, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_for_results();
    endtask

    task test_valid_sequences;
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        wait_for_results();
    endtask

    task test_broken_sequences;
        // Surrogate and overlong second bytes break the sequence.
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h8F, 1'b0);
        // ASCII breaking a sequence gives two characters.
        send_byte(8'hDF, 1'b0);
        send_byte(8'h41, 1'b0);
        // A new lead breaking a sequence starts one of its own.
        send_byte(8'hE1, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hBF, 1'b0);
        wait_for_results();
    endtask

    task test_truncation;
        send_byte(8'hF1, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hF4, 1'b1);
        send_byte(8'h41, 1'b1);
        wait_for_results();
    endtask

    task test_random_traffic(input int idle_pct, input int hold_pct, input int n_bytes);
        int stop_at;
        int len;
        int pick;
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            len = $urandom_range(4, 1);
            if (pick < 70)
                send_scalar(pick_scalar(len), len, len);
            else if (pick < 80)
                send_scalar(pick_scalar(len), len, (len > 1) ? $urandom_range(len - 1, 1) : 1);
            else if (pick < 88)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        send_byte(8'hE0, 1'b0);
                        send_byte(8'($urandom_range(8'h9F, 8'h80)), random_end());
                    end
                    1:
                    begin
                        send_byte(8'hED, 1'b0);
                        send_byte(8'($urandom_range(8'hBF, 8'hA0)), random_end());
                    end
                    2:
                    begin
                        send_byte(8'hF0, 1'b0);
                        send_byte(8'($urandom_range(8'h8F, 8'h80)), random_end());
                    end
                    default:
                    begin
                        send_byte(8'hF4, 1'b0);
                        send_byte(8'($urandom_range(8'hBF, 8'h90)), random_end());
                    end
                endcase
            end
            else
                send_byte(8'($urandom_range(255)), random_end());
            if ($urandom_range(199) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial
    begin
        clear_sequence();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 15;
        stall_pct = 49;
        test_single_bytes();
        test_valid_sequences();
        test_broken_sequences();
        test_truncation();

        test_random_traffic(15, 49, PHASE_BYTES);
        test_random_traffic(49, 15, PHASE_BYTES);
        test_random_traffic(0, 0, PHASE_BYTES);

        wait_for_results();
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d bytes and checked %0d characters: %0d malformed, %0d texts closed,",
                 bytes_sent, chars_checked, malformed_count, texts_closed);
        $display("%0d bytes gave two characters; three pacing regimes were exercised.",
                 double_bytes);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/u8d_pkg.sv
design/u8d_queue.sv
design/u8d_front.sv
design/u8d_back.sv
design/utf8_stream_decoder.sv
design/u8d_checker.sv
sim/utf8_stream_decoder_test.sv
